// File: sv/fsbt_pkg.sv
// ============================================================================
// fsbt_pkg: shared types and constants for the string/bar time-step core
// Field widths, configuration register indexes, request codes, bank
// rotation codes, controller states and the command/status bundles.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fsbt_pkg;

    // Default sizes and fixed field widths
    localparam int GRID_POINTS_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 28;
    localparam int DATA_W          = 32;
    localparam int COEF_W          = 32;
    localparam int OUT_W           = 32;
    localparam int IDX_W           = 6;
    localparam int MARGIN_W        = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_COEFS       = 5;
    localparam int NUM_BANKS       = 3;
    localparam int MIN_MARGIN      = 2;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CENTER_COEF      = 3'd0;
    localparam t_cfg_idx CFG_NEAR_COEF        = 3'd1;
    localparam t_cfg_idx CFG_FAR_COEF         = 3'd2;
    localparam t_cfg_idx CFG_PREV_CENTER_COEF = 3'd3;
    localparam t_cfg_idx CFG_PREV_NEAR_COEF   = 3'd4;
    localparam t_cfg_idx CFG_LAST_POINT       = 3'd5;
    localparam t_cfg_idx CFG_EDGE_MARGIN      = 3'd6;

    // Request codes
    localparam logic REQ_STEP   = 1'b0;
    localparam logic REQ_EXCITE = 1'b1;

    // Grid bank identifiers
    typedef logic [1:0] t_bank;
    localparam t_bank BANK_A = 2'd0;
    localparam t_bank BANK_B = 2'd1;
    localparam t_bank BANK_C = 2'd2;

    // Which bank receives the next grid
    typedef enum logic [1:0] {
        ROT_A_NEXT,
        ROT_B_NEXT,
        ROT_C_NEXT
    } t_rot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_RUN,
        ST_STEP_DRAIN,
        ST_EXC_READ,
        ST_EXC_WRITE
    } t_state;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         point_index;
        logic signed [DATA_W-1:0] add_value;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic signed [OUT_W-1:0] displacement;
        logic                    last;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step_start;
        logic step_read;
        logic rotate;
        logic exc_read;
        logic exc_write;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic read_last;
        logic pipe_busy;
    } t_status;

endpackage

`default_nettype wire

// File: sv/fsbt_ctrl.sv
// ============================================================================
// fsbt_ctrl: sequencer for step and excite requests
// Walks the read sweep of a step, waits for the stencil pipeline to drain,
// then rotates the banks; runs the read/write pair of an excite.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fsbt_ctrl
    import fsbt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_req_type,
    input  wire t_status i_sts,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_req_type == REQ_EXCITE) begin
                        n_state = ST_EXC_READ;
                    end else begin
                        o_cmd.step_start = 1'b1;
                        n_state          = ST_STEP_RUN;
                    end
                end
            end
            ST_STEP_RUN: begin
                o_cmd.step_read = 1'b1;
                if (i_sts.read_last) begin
                    n_state = ST_STEP_DRAIN;
                end
            end
            ST_STEP_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.rotate = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_EXC_READ: begin
                o_cmd.exc_read = 1'b1;
                n_state        = ST_EXC_WRITE;
            end
            ST_EXC_WRITE: begin
                o_cmd.exc_write = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: sv/fsbt_datapath.sv
// ============================================================================
// fsbt_datapath: grid banks, configuration registers and stencil pipeline
// Three rotating grid memories with per-entry valid flags, a sliding window
// over the current and previous grids, five multipliers (three on pre-added
// neighbor pairs), a registered adder tree, rounding and saturation.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fsbt_datapath
    import fsbt_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_sts,
    input  wire t_req              i_req,
    input  wire logic              i_cfg_valid,
    input  wire t_cfg_idx          i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_data,
    output logic                   o_result_strobe,
    output t_result                o_result
);

    localparam int IW        = $clog2(GRID_POINTS);
    localparam int CW        = IW + 1;
    localparam int VW        = VALUE_WIDTH;
    localparam int SW        = VW + 1;
    localparam int PW        = SW + COEF_W;
    localparam int AW        = PW + 3;
    localparam int EW        = ((VW > DATA_W) ? VW : DATA_W) + 1;
    localparam int OE        = (VW < OUT_W) ? VW : OUT_W;
    localparam int LAST_MAX  = GRID_POINTS - 1;
    localparam int PIDX_W    = IDX_W + 1;
    localparam int TAG_DEPTH = 7;
    localparam int TAG_OUT   = TAG_DEPTH - 1;

    localparam logic signed [PW:0] RND_HALF =
        {{(PW - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [AW-1:0] ACC_VMAX = {{(AW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_VMIN = ~ACC_VMAX;
    localparam logic signed [AW-1:0] ACC_OMAX = {{(AW - OE + 1){1'b0}}, {(OE - 1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_OMIN = ~ACC_OMAX;
    localparam logic signed [EW-1:0] EXC_VMAX = {{(EW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [EW-1:0] EXC_VMIN = ~EXC_VMAX;

    typedef struct packed {
        logic          v;
        logic          emit;
        logic          interior;
        logic          last;
        logic [IW-1:0] l;
    } t_tag;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] r_coef [NUM_COEFS];
    logic [IDX_W-1:0]         r_last_point;
    logic [MARGIN_W-1:0]      r_edge_margin;

    // Take a register write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
            r_last_point  <= IDX_W'(63);
            r_edge_margin <= MARGIN_W'(MIN_MARGIN);
        end else if (i_cfg_valid) begin
            case (i_cfg_index) inside
                CFG_CENTER_COEF, CFG_NEAR_COEF, CFG_FAR_COEF,
                CFG_PREV_CENTER_COEF, CFG_PREV_NEAR_COEF: begin
                    r_coef[i_cfg_index] <= i_cfg_data;
                end
                CFG_LAST_POINT: begin
                    r_last_point <= i_cfg_data[IDX_W-1:0];
                end
                CFG_EDGE_MARGIN: begin
                    r_edge_margin <= i_cfg_data[MARGIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic [IW-1:0]       last_eff;
    logic [MARGIN_W-1:0] margin_eff;

    // Clamp last point to the grid and the margin to its floor
    always_comb begin
        last_eff   = (r_last_point > IDX_W'(LAST_MAX)) ? IW'(LAST_MAX)
                                                       : IW'(r_last_point);
        margin_eff = (r_edge_margin < MARGIN_W'(MIN_MARGIN)) ? MARGIN_W'(MIN_MARGIN)
                                                             : r_edge_margin;
    end

    // ------------------------------------------------------------------
    // Request latch, sweep counter, bank rotation
    // ------------------------------------------------------------------
    t_req          r_req;
    logic [CW-1:0] r_cnt;
    t_rot          r_rot;
    t_bank         nxt_sel;
    t_bank         cur_sel;
    t_bank         prv_sel;

    // Hold the request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // Advance the read sweep and rotate banks at the end of a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rot <= ROT_A_NEXT;
        end else begin
            if (i_cmd.step_start) begin
                r_cnt <= '0;
            end else if (i_cmd.step_read) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.rotate) begin
                unique case (r_rot)
                    ROT_A_NEXT: r_rot <= ROT_C_NEXT;
                    ROT_B_NEXT: r_rot <= ROT_A_NEXT;
                    ROT_C_NEXT: r_rot <= ROT_B_NEXT;
                    default:    r_rot <= ROT_A_NEXT;
                endcase
            end
        end
    end

    // Decode bank roles
    always_comb begin
        unique case (r_rot)
            ROT_A_NEXT: begin
                nxt_sel = BANK_A; cur_sel = BANK_B; prv_sel = BANK_C;
            end
            ROT_B_NEXT: begin
                nxt_sel = BANK_B; cur_sel = BANK_C; prv_sel = BANK_A;
            end
            ROT_C_NEXT: begin
                nxt_sel = BANK_C; cur_sel = BANK_A; prv_sel = BANK_B;
            end
            default: begin
                nxt_sel = BANK_A; cur_sel = BANK_B; prv_sel = BANK_C;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Grid banks
    // ------------------------------------------------------------------
    logic signed [VW-1:0] r_mem [NUM_BANKS][GRID_POINTS];
    logic [GRID_POINTS-1:0] r_vld [NUM_BANKS];
    logic signed [VW-1:0] r_rdq [NUM_BANKS];
    logic                 r_rdv [NUM_BANKS];

    logic                 exc_ok;
    logic [IW-1:0]        exc_idx;
    logic [IW-1:0]        raddr;
    logic [IW-1:0]        waddr;
    logic                 step_wr;
    logic                 exc_wr;
    logic                 we    [NUM_BANKS];
    logic signed [VW-1:0] wdata [NUM_BANKS];

    logic signed [VW-1:0] cur_rd;
    logic signed [VW-1:0] prv_rd;
    logic signed [EW-1:0] exc_cur_sum;
    logic signed [EW-1:0] exc_prv_sum;
    logic signed [VW-1:0] exc_cur_new;
    logic signed [VW-1:0] exc_prv_new;

    t_tag                 r_tag [TAG_DEPTH];
    logic signed [VW-1:0] r_new;
    logic signed [OUT_W-1:0] r_out;

    // Entries not written since their bank was last cleared read as zero
    assign cur_rd = r_rdv[cur_sel] ? r_rdq[cur_sel] : '0;
    assign prv_rd = r_rdv[prv_sel] ? r_rdq[prv_sel] : '0;

    // Excite point must lie strictly inside the string
    always_comb begin
        exc_ok  = (r_req.point_index != '0) &&
                  ((PIDX_W'(r_req.point_index) + PIDX_W'(1)) <= PIDX_W'(last_eff));
        exc_idx = r_req.point_index[IW-1:0];
        raddr   = i_cmd.exc_read ? exc_idx : r_cnt[IW-1:0];
    end

    // Saturating add of the excitation to current and previous grid
    always_comb begin
        exc_cur_sum = EW'(cur_rd) + EW'(r_req.add_value);
        exc_prv_sum = EW'(prv_rd) + EW'(r_req.add_value);
        exc_cur_new = (exc_cur_sum > EXC_VMAX) ? VW'(EXC_VMAX) :
                      (exc_cur_sum < EXC_VMIN) ? VW'(EXC_VMIN) : VW'(exc_cur_sum);
        exc_prv_new = (exc_prv_sum > EXC_VMAX) ? VW'(EXC_VMAX) :
                      (exc_prv_sum < EXC_VMIN) ? VW'(EXC_VMIN) : VW'(exc_prv_sum);
    end

    // Steer writes: step results into the next bank, excitation into two
    always_comb begin
        step_wr = r_tag[TAG_OUT].v && r_tag[TAG_OUT].interior;
        exc_wr  = i_cmd.exc_write && exc_ok;
        waddr   = step_wr ? r_tag[TAG_OUT].l : exc_idx;
        for (int b = 0; b < NUM_BANKS; b++) begin
            we[b]    = (step_wr && (nxt_sel == t_bank'(b))) ||
                       (exc_wr && ((cur_sel == t_bank'(b)) || (prv_sel == t_bank'(b))));
            wdata[b] = step_wr ? r_new :
                       ((cur_sel == t_bank'(b)) ? exc_cur_new : exc_prv_new);
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (we[b]) begin
                r_mem[b][waddr] <= wdata[b];
            end
            r_rdq[b] <= r_mem[b][raddr];
        end
    end

    // Valid flags: drop the whole next bank at step start, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_vld[b] <= '0;
                r_rdv[b] <= 1'b0;
            end
        end else begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                if (i_cmd.step_start && (nxt_sel == t_bank'(b))) begin
                    r_vld[b] <= '0;
                end else if (we[b]) begin
                    r_vld[b][waddr] <= 1'b1;
                end
                r_rdv[b] <= r_vld[b][raddr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stencil pipeline
    // ------------------------------------------------------------------
    logic                 r_s1_v;
    logic [CW-1:0]        r_s1_j;
    logic signed [VW-1:0] r_cw [5];
    logic signed [VW-1:0] r_pw [4];
    logic [CW-1:0]        l_w;
    t_tag                 n_tag;

    logic signed [VW-1:0] r_cs;
    logic signed [SW-1:0] r_cn;
    logic signed [SW-1:0] r_cf;
    logic signed [VW-1:0] r_pc;
    logic signed [SW-1:0] r_pn;
    logic signed [PW-1:0] r_pr [NUM_COEFS];
    logic signed [PW:0]   r_a0;
    logic signed [PW:0]   r_a1;
    logic signed [PW:0]   r_a2;
    logic signed [PW+1:0] r_b0;
    logic signed [PW:0]   r_b1;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] acc_sh;
    logic signed [AW-1:0] sat_v;
    logic signed [AW-1:0] sat_o;

    // Issue stage: mark the read that is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.step_read;
        end
        r_s1_j <= r_cnt;
    end

    // Point centered in the window once the read of index j has landed
    always_comb begin
        l_w            = r_s1_j - CW'(2);
        n_tag.v        = r_s1_v;
        n_tag.emit     = (r_s1_j >= CW'(2));
        n_tag.interior = n_tag.emit && (l_w >= CW'(margin_eff)) &&
                         ((l_w + CW'(margin_eff)) <= CW'(last_eff));
        n_tag.last     = n_tag.emit && (l_w == CW'(last_eff));
        n_tag.l        = l_w[IW-1:0];
    end

    // Shift the read data into the sliding windows
    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            for (int k = 0; k < 4; k++) begin
                r_cw[k] <= r_cw[k+1];
            end
            r_cw[4] <= cur_rd;
            for (int k = 0; k < 3; k++) begin
                r_pw[k] <= r_pw[k+1];
            end
            r_pw[3] <= prv_rd;
        end
    end

    // Advance tags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAG_DEPTH; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= n_tag;
            for (int k = 1; k < TAG_DEPTH; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // Pre-add symmetric pairs, multiply, reduce, round
    always_ff @(posedge i_clk) begin
        r_cs <= r_cw[2];
        r_cn <= SW'(r_cw[1]) + SW'(r_cw[3]);
        r_cf <= SW'(r_cw[0]) + SW'(r_cw[4]);
        r_pc <= r_pw[1];
        r_pn <= SW'(r_pw[0]) + SW'(r_pw[2]);

        r_pr[0] <= PW'(r_cs) * PW'(r_coef[0]);
        r_pr[1] <= PW'(r_cn) * PW'(r_coef[1]);
        r_pr[2] <= PW'(r_cf) * PW'(r_coef[2]);
        r_pr[3] <= PW'(r_pc) * PW'(r_coef[3]);
        r_pr[4] <= PW'(r_pn) * PW'(r_coef[4]);

        r_a0 <= (PW+1)'(r_pr[0]) + (PW+1)'(r_pr[1]);
        r_a1 <= (PW+1)'(r_pr[2]) + (PW+1)'(r_pr[3]);
        r_a2 <= (PW+1)'(r_pr[4]) + RND_HALF;

        r_b0 <= (PW+2)'(r_a0) + (PW+2)'(r_a1);
        r_b1 <= r_a2;

        r_acc <= AW'(r_b0) + AW'(r_b1);
    end

    // Drop the fraction and saturate to grid and output widths
    always_comb begin
        acc_sh = r_acc >>> FRAC_BITS;
        sat_v  = (acc_sh > ACC_VMAX) ? ACC_VMAX : (acc_sh < ACC_VMIN) ? ACC_VMIN : acc_sh;
        sat_o  = (acc_sh > ACC_OMAX) ? ACC_OMAX : (acc_sh < ACC_OMIN) ? ACC_OMIN : acc_sh;
    end

    // Boundary points come out as zero
    always_ff @(posedge i_clk) begin
        r_new <= r_tag[TAG_OUT-1].interior ? VW'(sat_v) : '0;
        r_out <= r_tag[TAG_OUT-1].interior ? OUT_W'(sat_o) : '0;
    end

    // Present one grid point per cycle
    always_comb begin
        o_result_strobe       = r_tag[TAG_OUT].v && r_tag[TAG_OUT].emit;
        o_result.out_index    = IDX_W'(r_tag[TAG_OUT].l);
        o_result.displacement = r_out;
        o_result.last         = r_tag[TAG_OUT].last;
    end

    // End of the read sweep and pipeline occupancy
    always_comb begin
        o_sts.read_last = (r_cnt == ({1'b0, last_eff} + CW'(2)));
        o_sts.pipe_busy = r_s1_v;
        for (int k = 0; k < TAG_DEPTH; k++) begin
            o_sts.pipe_busy = o_sts.pipe_busy | r_tag[k].v;
        end
    end

`ifndef SYNTHESIS
    a_clear_not_with_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_start |-> !step_wr)
        else $error("next bank cleared while a step result is written");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag[TAG_OUT].v && r_tag[TAG_OUT].last) |=> !r_tag[TAG_OUT].v)
        else $error("grid point follows the final point of a step");

    a_excite_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exc_write |-> !o_sts.pipe_busy)
        else $error("excite write while stencil pipeline active");

    a_interior_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag[TAG_OUT].v && r_tag[TAG_OUT].interior) |->
            (r_tag[TAG_OUT].emit && !r_tag[TAG_OUT].last))
        else $error("interior point outside the emitted run");
`endif

endmodule

`default_nettype wire

// File: sv/fd_string_bar_time_step_core.sv
// ============================================================================
// fd_string_bar_time_step_core: damped string/bar finite-difference step
// Top level: sequencer plus datapath holding three rotating grids and a
// symmetric five-coefficient stencil pipeline.
// ============================================================================
//
//  channel   | signals                                  | flow
//  ----------+------------------------------------------+------------------------
//  request   | start, busy, i_req                       | in, taken at start & !busy
//  result    | o_result_strobe, o_result                | out, one cycle each
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,   | in, taken at valid & ready
//            | i_cfg_data                               |
//
//  During a step the single read port of each grid bank sweeps one point
//  per cycle, followed by an eight-stage stencil pipeline. Results leave
//  one per cycle, in index order. An excite reads the point, adds the value
//  with saturation and writes it back into the current and previous grids.
//  Synchronous active-low reset zeroes all three grids at once through
//  per-entry valid flags. Results cannot be stalled; config is always ready.
//
`timescale 1ns / 1ps
`default_nettype none

module fd_string_bar_time_step_core
    import fsbt_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_req              i_req,
    output logic                   o_result_strobe,
    output t_result                o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire t_cfg_idx          i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    fsbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Grids and stencil arithmetic
    fsbt_datapath #(
        .GRID_POINTS (GRID_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req           (i_req),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

`default_nettype wire
